// ----- rtl/core/ideip_pkg.sv -----
`timescale 1ns / 1ps

package ideip_pkg;

  typedef enum logic [2:0] {
    OpMem     = 3'd0,
    OpIoRead  = 3'd1,
    OpIoWrite = 3'd2,
    OpAutomap = 3'd3,
    OpSoftRst = 3'd4,
    OpHardRst = 3'd5,
    OpRsvd6   = 3'd6,
    OpRsvd7   = 3'd7
  } ideip_op_e;

  localparam int unsigned CtlConmemBit = 7;
  localparam int unsigned CtlMapramBit = 6;
  localparam logic [7:0]  CtlMapram    = 8'h40;
  localparam logic [7:0]  IdeMask      = 8'he3;
  localparam logic [7:0]  IdeMatch     = 8'ha3;
  localparam logic [7:0]  CtlPortMatch = 8'he3;
  localparam logic [7:0]  MapramLowPg  = 8'd3;

  typedef struct packed {
    logic [7:0] ctl;
    logic       automap;
    logic       paged;
  } ideip_state_t;

  typedef struct packed {
    logic        hit;
    logic        source;
    logic [1:0]  page;
    logic [12:0] offset;
    logic        writable;
    logic        claimed;
    logic        ide;
    logic [2:0]  ide_reg;
    logic        ctl_wr;
  } ideip_dec_t;

  typedef struct packed {
    logic [7:0]  control_value;
    logic [2:0]  taskfile_reg;
    logic        ide_access;
    logic        io_claimed;
    logic        mem_writable;
    logic [12:0] mem_offset;
    logic [1:0]  mem_page;
    logic        mem_source;
    logic        mem_hit;
    logic        paged;
  } ideip_res_t;

endpackage

// ----- rtl/core/ideip_decode.sv -----
`timescale 1ns / 1ps

module ideip_decode #(
  parameter int unsigned RAM_PAGES = 4
) (
  input  logic [2:0]          op_i,
  input  logic [15:0]         addr_i,
  input  logic                wp_i,
  input  ideip_pkg::ideip_state_t state_i,
  output ideip_pkg::ideip_dec_t   dec_o
);
  import ideip_pkg::*;

  localparam logic [7:0] PageMask = 8'(RAM_PAGES - 1);
  localparam logic [7:0] LowPage  = MapramLowPg & PageMask;

  logic [7:0] upper;
  logic       conmem;
  logic       mapram;
  logic       is_io;
  logic       ide_hit;

  assign upper   = state_i.ctl & PageMask;
  assign conmem  = state_i.ctl[CtlConmemBit];
  assign mapram  = state_i.ctl[CtlMapramBit];
  assign is_io   = (op_i == OpIoRead) || (op_i == OpIoWrite);
  assign ide_hit = (addr_i[7:0] & IdeMask) == IdeMatch;

  always_comb begin
    dec_o = '0;
    if (op_i == OpMem && state_i.paged && addr_i[15:14] == 2'b00) begin
      dec_o.hit    = 1'b1;
      dec_o.offset = addr_i[12:0];
      if (!addr_i[13]) begin
        priority if (conmem) begin
          dec_o.source   = 1'b0;
          dec_o.writable = !wp_i;
        end else if (mapram) begin
          dec_o.source = 1'b1;
          dec_o.page   = LowPage[1:0];
        end else begin
          dec_o.source = 1'b0;
        end
      end else begin
        dec_o.source   = 1'b1;
        dec_o.page     = upper[1:0];
        dec_o.writable = (!conmem && mapram) ? (upper != MapramLowPg) : 1'b1;
      end
    end
    if (is_io) begin
      if (ide_hit) begin
        dec_o.claimed = 1'b1;
        dec_o.ide     = 1'b1;
        dec_o.ide_reg = addr_i[4:2];
      end else if (op_i == OpIoWrite && addr_i[7:0] == CtlPortMatch) begin
        dec_o.claimed = 1'b1;
        dec_o.ctl_wr  = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ideip_state.sv -----
`timescale 1ns / 1ps

module ideip_state (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic [2:0]              op_i,
  input  logic                    ctl_wr_i,
  input  logic [7:0]              data_i,
  input  logic                    level_i,
  input  logic                    wp_i,
  output ideip_pkg::ideip_state_t state_q_o,
  output ideip_pkg::ideip_state_t state_d_o
);
  import ideip_pkg::*;

  ideip_state_t state_q;
  ideip_state_t state_d;
  logic         recompute;

  always_comb begin
    state_d   = state_q;
    recompute = 1'b0;
    unique case (op_i)
      OpIoRead, OpIoWrite: begin
        if (ctl_wr_i) begin
          state_d.ctl = data_i | (state_q.ctl & CtlMapram);
          recompute   = 1'b1;
        end
      end
      OpAutomap: begin
        state_d.automap = level_i;
        recompute       = 1'b1;
      end
      OpSoftRst: begin
        state_d.ctl     = state_q.ctl & CtlMapram;
        state_d.automap = 1'b0;
        recompute       = 1'b1;
      end
      OpHardRst: begin
        state_d.ctl     = '0;
        state_d.automap = 1'b0;
        recompute       = 1'b1;
      end
      default: begin
      end
    endcase
    if (recompute) begin
      priority if (state_d.ctl[CtlConmemBit]) begin
        state_d.paged = 1'b1;
      end else if (wp_i || state_d.ctl[CtlMapramBit]) begin
        state_d.paged = state_d.automap;
      end else begin
        state_d.paged = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign state_q_o = state_q;
  assign state_d_o = state_d;

endmodule

// ----- rtl/core/ide_interface_memory_paging_unit.sv -----
`timescale 1ns / 1ps
// An accepted input is held in the input register, then passes to the result register.
// Throughput: one item per cycle unless the output stalls; the paging state updates as an item
// moves to the result register, so back-to-back items see the state left by the one before.
// Reset: asynchronous, active low; clears the control byte, automap and paged flags,
// the write-protect register and both valid flags.
module ide_interface_memory_paging_unit #(
  parameter int unsigned RAM_PAGES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // address[15:0], data[23:16], automap_level[24], zero
  input  logic [2:0]  s_axis_tuser_i,  // operation[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // paged[0], mem_hit[1], mem_source[2], mem_page[4:3], mem_offset[17:5],
  // mem_writable[18], io_claimed[19], ide_access[20], taskfile_reg[23:21],
  // control_value[31:24]
  output logic [31:0] m_axis_tdata_o
);
  import ideip_pkg::*;

  logic         wp_q;
  logic         in_valid_q;
  logic [2:0]   op_q;
  logic [15:0]  addr_q;
  logic [7:0]   data_q;
  logic         level_q;
  logic         out_valid_q;
  ideip_res_t   res_q;
  ideip_res_t   res_d;
  logic         advance;
  logic         s_take;
  ideip_dec_t   dec;
  ideip_state_t state_q;
  ideip_state_t state_d;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
    end else if (cfg_we_i) begin
      wp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      op_q    <= s_axis_tuser_i;
      addr_q  <= s_axis_tdata_i[15:0];
      data_q  <= s_axis_tdata_i[23:16];
      level_q <= s_axis_tdata_i[24];
    end
  end

  ideip_decode #(
    .RAM_PAGES(RAM_PAGES)
  ) u_decode (
    .op_i   (op_q),
    .addr_i (addr_q),
    .wp_i   (wp_q),
    .state_i(state_q),
    .dec_o  (dec)
  );

  ideip_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .op_i     (op_q),
    .ctl_wr_i (dec.ctl_wr),
    .data_i   (data_q),
    .level_i  (level_q),
    .wp_i     (wp_q),
    .state_q_o(state_q),
    .state_d_o(state_d)
  );

  always_comb begin
    res_d.paged         = state_d.paged;
    res_d.mem_hit       = dec.hit;
    res_d.mem_source    = dec.source;
    res_d.mem_page      = dec.page;
    res_d.mem_offset    = dec.offset;
    res_d.mem_writable  = dec.writable;
    res_d.io_claimed    = dec.claimed;
    res_d.ide_access    = dec.ide;
    res_d.taskfile_reg  = dec.ide_reg;
    res_d.control_value = state_d.ctl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

  a_mapram_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.ctl[CtlMapramBit] && op_q != OpHardRst) |=>
      state_q.ctl[CtlMapramBit])
    else $error("map-RAM bit cleared without hard reset");

  a_conmem_paged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ctl[CtlConmemBit] |-> state_q.paged)
    else $error("memory-conflict mode without paged flag");

  a_hit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.mem_hit) |-> (res_q.paged && !res_q.io_claimed))
    else $error("memory hit with io claim or while unpaged");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("paging state changed without an item");

endmodule
